// ----- rtl/mfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor fault supervisor package
// Widths, reset values, register indexes and result codes shared by the
// supervisor, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package mfs_pkg;

	localparam int CFG_DATA_W    = 32;
	localparam int CFG_INDEX_W   = 3;

	localparam int CUR_LIMIT_W   = 15;
	localparam int VOLT_LIMIT_W  = 16;
	localparam int STALL_SPEED_W = 15;
	localparam int STALL_MAX_W   = 16;
	localparam int COST_W        = 32;
	localparam int STALL_COUNT_W = 17;
	localparam int LIM2_W        = 2 * CUR_LIMIT_W;
	localparam int NINE_LIM2_W   = LIM2_W + 4;
	localparam int HC_SPLIT      = 34;
	localparam int HC_PROD_W     = HC_SPLIT + 5;
	localparam int MODE_W        = 2;
	localparam int CAUSE_W       = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_LIMIT   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_LIMIT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_STALL_SPEED     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STALL_COUNT_MAX = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_DIV_LIMIT       = 3'd4;

	localparam logic [CUR_LIMIT_W-1:0]   CUR_LIMIT_RST   = 15'h7FFF;
	localparam logic [VOLT_LIMIT_W-1:0]  VOLT_LIMIT_RST  = 16'hFFFF;
	localparam logic [STALL_SPEED_W-1:0] STALL_SPEED_RST = 15'h0000;
	localparam logic [STALL_MAX_W-1:0]   STALL_MAX_RST   = 16'hFFFF;
	localparam logic [COST_W-1:0]        DIV_LIMIT_RST   = 32'hFFFF_FFFF;
	localparam logic [LIM2_W-1:0]        LIM2_RST        =
		LIM2_W'(64'(CUR_LIMIT_RST) * 64'(CUR_LIMIT_RST));
	localparam logic [NINE_LIM2_W-1:0]   NINE_LIM2_RST   =
		NINE_LIM2_W'(64'd9 * 64'(LIM2_RST));
	localparam logic [STALL_COUNT_W-1:0] STALL_COUNT_TOP = 17'h1FFFF;
	localparam logic [HC_PROD_W-1:0]     HC_FACTOR       = 39'd25;

	typedef enum logic [MODE_W-1:0] {
		MODE_NORMAL   = 2'd0,
		MODE_FAULT    = 2'd1,
		MODE_DEGRADED = 2'd2
	} mode_t;

	typedef enum logic [CAUSE_W-1:0] {
		CAUSE_NONE         = 3'd0,
		CAUSE_OVERCURRENT  = 3'd1,
		CAUSE_OVERVOLTAGE  = 3'd2,
		CAUSE_STALL        = 3'd3,
		CAUSE_DIVERGED     = 3'd4
	} cause_t;

endpackage

// ----- rtl/mfs_if.sv -----
// ----------------------------------------------------------------------------
// Motor fault supervisor channels
// Valid/ready channels for the sample going in and the verdict coming out.
// ----------------------------------------------------------------------------
interface mfs_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                            valid;
	logic                            ready;
	logic signed [SAMPLE_WIDTH-1:0]  current_alpha;
	logic signed [SAMPLE_WIDTH-1:0]  current_beta;
	logic [SAMPLE_WIDTH-1:0]         bus_voltage;
	logic signed [SAMPLE_WIDTH-1:0]  rotor_speed;
	logic [mfs_pkg::COST_W-1:0]      control_cost;

	modport source (
		output valid, current_alpha, current_beta, bus_voltage, rotor_speed, control_cost,
		input  ready
	);
	modport sink (
		input  valid, current_alpha, current_beta, bus_voltage, rotor_speed, control_cost,
		output ready
	);
endinterface

interface mfs_result_if;
	logic           valid;
	logic           ready;
	mfs_pkg::mode_t  mode;
	mfs_pkg::cause_t cause;

	modport source (
		output valid, mode, cause,
		input  ready
	);
	modport sink (
		input  valid, mode, cause,
		output ready
	);
endinterface

// ----- rtl/motor_fault_supervisor.sv -----
// ----------------------------------------------------------------------------
// Motor fault supervisor
// Each sample yields one (mode, cause) verdict. All checks for a sample run in
// one pass between the input register and the result register, so a sample's
// verdict enters the result register when it can, and a new sample can be
// accepted every cycle unless both are full and stalled. While the result is
// held off the block keeps up to two samples, one in each register, and once
// both are full sample.ready follows result.ready in the same cycle. A register
// write takes effect for the sample accepted at the same edge; the squared
// current limit and nine times it are formed when current_limit is written.
// ----------------------------------------------------------------------------
module motor_fault_supervisor #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [mfs_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mfs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	mfs_sample_if.sink                          sample,
	mfs_result_if.source                        result
);

	localparam int SUM_W = 2 * SAMPLE_WIDTH;
	localparam int HC_W  = (SUM_W > mfs_pkg::HC_SPLIT) ? SUM_W : mfs_pkg::HC_SPLIT + 1;
	localparam int CMP_W = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;

	logic [mfs_pkg::VOLT_LIMIT_W-1:0]  voltage_limit_q;
	logic [mfs_pkg::STALL_SPEED_W-1:0] stall_speed_q;
	logic [mfs_pkg::STALL_MAX_W-1:0]   stall_count_max_q;
	logic [mfs_pkg::COST_W-1:0]        div_limit_q;
	logic [mfs_pkg::LIM2_W-1:0]        lim2_q;
	logic [mfs_pkg::NINE_LIM2_W-1:0]   nine_lim2_q;
	logic [mfs_pkg::STALL_COUNT_W-1:0] stall_count_q;

	logic                          valid_s1;
	logic [SAMPLE_WIDTH-1:0]       alpha_s1;
	logic [SAMPLE_WIDTH-1:0]       beta_s1;
	logic [SAMPLE_WIDTH-1:0]       voltage_s1;
	logic [SAMPLE_WIDTH-1:0]       speed_s1;
	logic [mfs_pkg::COST_W-1:0]    cost_s1;

	logic                          out_valid_q;
	mfs_pkg::mode_t                mode_q;
	mfs_pkg::cause_t               cause_q;

	logic ready_out, ready_s1;
	logic move_in, move_s1;

	logic [mfs_pkg::CUR_LIMIT_W-1:0] cfg_limit;
	logic [mfs_pkg::LIM2_W-1:0]      lim2_wr;
	logic [mfs_pkg::NINE_LIM2_W-1:0] nine_lim2_wr;

	logic [SAMPLE_WIDTH-1:0]       mag_a, mag_b, mag_speed;
	logic [SUM_W-1:0]              sq_a, sq_b, sum;
	logic [HC_W-1:0]               sum_ext;
	logic [mfs_pkg::HC_PROD_W-1:0] sum_low, prod25;
	logic                          over_current, over_voltage, low_speed, over_cost;
	logic                          high_current, fault;
	logic [mfs_pkg::STALL_COUNT_W-1:0] count_next;
	mfs_pkg::mode_t                mode_next;
	mfs_pkg::cause_t               cause_next;

	assign ready_out = !out_valid_q || result.ready;
	assign ready_s1  = !valid_s1 || ready_out;
	assign move_in   = sample.valid && ready_s1;
	assign move_s1   = valid_s1 && ready_out;

	assign sample.ready = ready_s1;
	assign result.valid = out_valid_q;
	assign result.mode  = mode_q;
	assign result.cause = cause_q;

	always_comb begin
		cfg_limit    = cfg_wdata[mfs_pkg::CUR_LIMIT_W-1:0];
		lim2_wr      = mfs_pkg::LIM2_W'(cfg_limit) * mfs_pkg::LIM2_W'(cfg_limit);
		nine_lim2_wr = mfs_pkg::NINE_LIM2_W'({lim2_wr, 3'b000}) +
			mfs_pkg::NINE_LIM2_W'(lim2_wr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_limit_q   <= mfs_pkg::VOLT_LIMIT_RST;
			stall_speed_q     <= mfs_pkg::STALL_SPEED_RST;
			stall_count_max_q <= mfs_pkg::STALL_MAX_RST;
			div_limit_q       <= mfs_pkg::DIV_LIMIT_RST;
			lim2_q            <= mfs_pkg::LIM2_RST;
			nine_lim2_q       <= mfs_pkg::NINE_LIM2_RST;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					mfs_pkg::CFG_CURRENT_LIMIT: begin
						lim2_q      <= lim2_wr;
						nine_lim2_q <= nine_lim2_wr;
					end
					mfs_pkg::CFG_VOLTAGE_LIMIT:
						voltage_limit_q <= cfg_wdata[mfs_pkg::VOLT_LIMIT_W-1:0];
					mfs_pkg::CFG_STALL_SPEED:
						stall_speed_q <= cfg_wdata[mfs_pkg::STALL_SPEED_W-1:0];
					mfs_pkg::CFG_STALL_COUNT_MAX:
						stall_count_max_q <= cfg_wdata[mfs_pkg::STALL_MAX_W-1:0];
					mfs_pkg::CFG_DIV_LIMIT:
						div_limit_q <= cfg_wdata[mfs_pkg::COST_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		mag_a     = alpha_s1[SAMPLE_WIDTH-1] ? (~alpha_s1 + SAMPLE_WIDTH'(1)) : alpha_s1;
		mag_b     = beta_s1[SAMPLE_WIDTH-1]  ? (~beta_s1 + SAMPLE_WIDTH'(1))  : beta_s1;
		mag_speed = speed_s1[SAMPLE_WIDTH-1] ? (~speed_s1 + SAMPLE_WIDTH'(1)) : speed_s1;
		sq_a      = SUM_W'(mag_a) * SUM_W'(mag_a);
		sq_b      = SUM_W'(mag_b) * SUM_W'(mag_b);
		sum       = sq_a + sq_b;
	end

	always_comb begin
		sum_ext      = HC_W'(sum);
		over_current = sum_ext > HC_W'(lim2_q);
		over_voltage = CMP_W'(voltage_s1) > CMP_W'(voltage_limit_q);
		low_speed    = CMP_W'(mag_speed) < CMP_W'(stall_speed_q);
		over_cost    = cost_s1 > div_limit_q;
		fault        = over_current || over_voltage;
		sum_low      = mfs_pkg::HC_PROD_W'(sum_ext[mfs_pkg::HC_SPLIT-1:0]);
		prod25       = sum_low * mfs_pkg::HC_FACTOR;
		high_current = (|sum_ext[HC_W-1:mfs_pkg::HC_SPLIT]) ||
			(prod25 > mfs_pkg::HC_PROD_W'(nine_lim2_q));
		count_next   = stall_count_q;
		if (low_speed && high_current) begin
			if (stall_count_q != mfs_pkg::STALL_COUNT_TOP) begin
				count_next = stall_count_q + mfs_pkg::STALL_COUNT_W'(1);
			end
		end else if (stall_count_q != '0) begin
			count_next = stall_count_q - mfs_pkg::STALL_COUNT_W'(1);
		end
		priority if (over_current) begin
			mode_next  = mfs_pkg::MODE_FAULT;
			cause_next = mfs_pkg::CAUSE_OVERCURRENT;
		end else if (over_voltage) begin
			mode_next  = mfs_pkg::MODE_FAULT;
			cause_next = mfs_pkg::CAUSE_OVERVOLTAGE;
		end else if (count_next > mfs_pkg::STALL_COUNT_W'(stall_count_max_q)) begin
			mode_next  = mfs_pkg::MODE_DEGRADED;
			cause_next = mfs_pkg::CAUSE_STALL;
		end else if (over_cost) begin
			mode_next  = mfs_pkg::MODE_DEGRADED;
			cause_next = mfs_pkg::CAUSE_DIVERGED;
		end else begin
			mode_next  = mfs_pkg::MODE_NORMAL;
			cause_next = mfs_pkg::CAUSE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			stall_count_q <= '0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= sample.valid;
			end
			if (ready_out) begin
				out_valid_q <= valid_s1;
			end
			if (move_s1 && !fault) begin
				stall_count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_in) begin
			alpha_s1   <= sample.current_alpha;
			beta_s1    <= sample.current_beta;
			voltage_s1 <= sample.bus_voltage;
			speed_s1   <= sample.rotor_speed;
			cost_s1    <= sample.control_cost;
		end
		if (move_s1) begin
			mode_q  <= mode_next;
			cause_q <= cause_next;
		end
	end

endmodule

// ----- rtl/mfs_checker.sv -----
// ----------------------------------------------------------------------------
// Motor fault supervisor checker
// Port-level checks on the sample and verdict channels, bound to the top.
// ----------------------------------------------------------------------------
module mfs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [mfs_pkg::MODE_W-1:0]    result_mode,
	input logic [mfs_pkg::CAUSE_W-1:0]   result_cause
);

	localparam logic [2:0] PIPE_DEPTH = 3'd2;

	logic [2:0] pending_q;
	logic       in_fire, out_fire;

	assign in_fire  = sample_valid && sample_ready;
	assign out_fire = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {2'b00, in_fire} - {2'b00, out_fire};
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(result_mode) && $stable(result_cause))
		else $error("Verdict changed or dropped while stalled.");

	a_code_pairing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(result_mode == mfs_pkg::MODE_NORMAL && result_cause == mfs_pkg::CAUSE_NONE) ||
			(result_mode == mfs_pkg::MODE_FAULT &&
				(result_cause == mfs_pkg::CAUSE_OVERCURRENT ||
				 result_cause == mfs_pkg::CAUSE_OVERVOLTAGE)) ||
			(result_mode == mfs_pkg::MODE_DEGRADED &&
				(result_cause == mfs_pkg::CAUSE_STALL ||
				 result_cause == mfs_pkg::CAUSE_DIVERGED)))
		else $error("Mode and cause do not agree.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != '0)
		else $error("Verdict without an outstanding sample.");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == PIPE_DEPTH && !result_ready |-> !sample_ready)
		else $error("Sample accepted with the pipeline full and the output stalled.");

endmodule

bind motor_fault_supervisor mfs_checker u_mfs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_mode  (result.mode),
	.result_cause (result.cause)
);

// ----- dv/mfs_verdict_checker.sv -----
// ----------------------------------------------------------------------------
// Motor fault supervisor verdict checker
// Watches the register port and both channels of the supervisor. Each accepted
// sample transaction is run through a local model of the fault priorities and
// the stall counter. The predicted verdict is queued, and each result
// transaction is compared field by field with the oldest verdict in the queue.
// ----------------------------------------------------------------------------
module mfs_verdict_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [mfs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mfs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	mfs_sample_if                           sample,
	mfs_result_if                           result,
	output int                              mismatches,
	output int                              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAG_W   = SAMPLE_WIDTH + 1;
	localparam int SUMSQ_W = 2 * MAG_W + 1;
	localparam int HCMP_W  = SUMSQ_W + 5;

	typedef struct packed {
		mfs_pkg::mode_t  mode;
		mfs_pkg::cause_t cause;
	} verdict_t;

	logic [mfs_pkg::CUR_LIMIT_W-1:0]   cur_limit;
	logic [mfs_pkg::VOLT_LIMIT_W-1:0]  volt_limit;
	logic [mfs_pkg::STALL_SPEED_W-1:0] stall_speed;
	logic [mfs_pkg::STALL_MAX_W-1:0]   stall_max;
	logic [mfs_pkg::COST_W-1:0]        div_limit;
	logic [mfs_pkg::STALL_COUNT_W-1:0] stall_count;
	verdict_t                          verdict_q[$];

	function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_WIDTH-1:0] raw);
		logic [MAG_W-1:0] wide;
		wide = {raw[SAMPLE_WIDTH-1], raw};
		return raw[SAMPLE_WIDTH-1] ? MAG_W'(-wide) : wide;
	endfunction

	function automatic verdict_t judge_sample(
		input logic [SAMPLE_WIDTH-1:0]    ia,
		input logic [SAMPLE_WIDTH-1:0]    ib,
		input logic [SAMPLE_WIDTH-1:0]    vdc,
		input logic [SAMPLE_WIDTH-1:0]    spd,
		input logic [mfs_pkg::COST_W-1:0] cost
	);
		logic [MAG_W-1:0]           mag_a;
		logic [MAG_W-1:0]           mag_b;
		logic [MAG_W-1:0]           mag_spd;
		logic [SUMSQ_W-1:0]         sumsq;
		logic [mfs_pkg::LIM2_W-1:0] lim2;
		logic                       high_current;
		verdict_t                   v;
		mag_a   = magnitude(ia);
		mag_b   = magnitude(ib);
		mag_spd = magnitude(spd);
		sumsq   = SUMSQ_W'(mag_a) * mag_a + SUMSQ_W'(mag_b) * mag_b;
		lim2    = mfs_pkg::LIM2_W'(cur_limit) * cur_limit;
		high_current = HCMP_W'(sumsq) * HCMP_W'(25) > HCMP_W'(lim2) * HCMP_W'(9);
		if (sumsq > SUMSQ_W'(lim2)) begin
			v.mode  = mfs_pkg::MODE_FAULT;
			v.cause = mfs_pkg::CAUSE_OVERCURRENT;
		end else if (vdc > volt_limit) begin
			v.mode  = mfs_pkg::MODE_FAULT;
			v.cause = mfs_pkg::CAUSE_OVERVOLTAGE;
		end else begin
			if (mag_spd < MAG_W'(stall_speed) && high_current) begin
				if (stall_count != mfs_pkg::STALL_COUNT_TOP)
					stall_count++;
			end else if (stall_count != '0) begin
				stall_count--;
			end
			if (stall_count > mfs_pkg::STALL_COUNT_W'(stall_max)) begin
				v.mode  = mfs_pkg::MODE_DEGRADED;
				v.cause = mfs_pkg::CAUSE_STALL;
			end else if (cost > div_limit) begin
				v.mode  = mfs_pkg::MODE_DEGRADED;
				v.cause = mfs_pkg::CAUSE_DIVERGED;
			end else begin
				v.mode  = mfs_pkg::MODE_NORMAL;
				v.cause = mfs_pkg::CAUSE_NONE;
			end
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			cur_limit   = mfs_pkg::CUR_LIMIT_RST;
			volt_limit  = mfs_pkg::VOLT_LIMIT_RST;
			stall_speed = mfs_pkg::STALL_SPEED_RST;
			stall_max   = mfs_pkg::STALL_MAX_RST;
			div_limit   = mfs_pkg::DIV_LIMIT_RST;
			stall_count = '0;
			verdict_q.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					mfs_pkg::CFG_CURRENT_LIMIT:
						cur_limit = cfg_wdata[mfs_pkg::CUR_LIMIT_W-1:0];
					mfs_pkg::CFG_VOLTAGE_LIMIT:
						volt_limit = cfg_wdata[mfs_pkg::VOLT_LIMIT_W-1:0];
					mfs_pkg::CFG_STALL_SPEED:
						stall_speed = cfg_wdata[mfs_pkg::STALL_SPEED_W-1:0];
					mfs_pkg::CFG_STALL_COUNT_MAX:
						stall_max = cfg_wdata[mfs_pkg::STALL_MAX_W-1:0];
					mfs_pkg::CFG_DIV_LIMIT:
						div_limit = cfg_wdata[mfs_pkg::COST_W-1:0];
					default: ;
				endcase
			end
			if (sample.valid && sample.ready)
				verdict_q.push_back(judge_sample(sample.current_alpha, sample.current_beta,
					sample.bus_voltage, sample.rotor_speed, sample.control_cost));
			if (result.valid && result.ready) begin
				if (verdict_q.size() == 0) begin
					$error("result transaction with no sample pending: mode %0d, cause %0d",
						result.mode, result.cause);
					mismatches++;
				end else begin
					want = verdict_q.pop_front();
					if (result.mode !== want.mode) begin
						$error("mode: expected %0d, actual %0d", want.mode, result.mode);
						mismatches++;
					end
					if (result.cause !== want.cause) begin
						$error("cause: expected %0d, actual %0d", want.cause, result.cause);
						mismatches++;
					end
				end
			end
		end
		outstanding = verdict_q.size();
	end

endmodule

// ----- dv/tb_motor_fault_supervisor.sv -----
// ----------------------------------------------------------------------------
// Motor fault supervisor testbench
// Drives samples and register settings into the supervisor, stalls both
// channels at random, and leaves prediction and comparison to the verdict
// checker. Directed samples cover the limits and priorities first, then runs
// of stall-building, calm and noisy samples follow under many settings, with a
// long receiver hold that fills the block and a full drain after it.
// ----------------------------------------------------------------------------
module tb_motor_fault_supervisor;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW             = 16;
	localparam int MAG_MAX        = 1 << (SW - 1);
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 60;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct {
		logic signed [SW-1:0]       ia;
		logic signed [SW-1:0]       ib;
		logic [SW-1:0]              vdc;
		logic signed [SW-1:0]       spd;
		logic [mfs_pkg::COST_W-1:0] cost;
	} sample_t;

	typedef enum int {
		RUN_STALL,
		RUN_CALM,
		RUN_NOISE
	} run_kind_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wen = 1'b0;
	logic [mfs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [mfs_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	mfs_sample_if #(.SAMPLE_WIDTH(SW)) sample ();
	mfs_result_if result ();

	int          mismatches;
	int          outstanding;
	int          idle_cycles;
	int          n_sent;
	int          n_settings;
	int          n_fault;
	int          n_degraded;
	bit          tx_idle_en;
	bit          rx_idle_en;
	bit          rx_hold_req;
	int          cur_lim;
	int          volt_lim;
	int          stall_spd;
	int          stall_max;
	logic [31:0] cost_lim;

	motor_fault_supervisor #(.SAMPLE_WIDTH(SW)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample),
		.result    (result)
	);

	mfs_verdict_checker #(.SAMPLE_WIDTH(SW)) verdict_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.sample      (sample),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (result.valid && result.ready) begin
			if (result.mode == mfs_pkg::MODE_FAULT)
				n_fault++;
			if (result.mode == mfs_pkg::MODE_DEGRADED)
				n_degraded++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The receiver either holds off for a long stretch on request, stalls in
	// short random bursts, or takes every result transaction.
	always begin
		@(negedge clk);
		if (rx_hold_req) begin
			result.ready = 1'b0;
			repeat (HOLD_CYCLES - 1) @(negedge clk);
			rx_hold_req = 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			result.ready = 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end else begin
			result.ready = 1'b1;
		end
	end

	function automatic logic signed [SW-1:0] signed_of(input int mag);
		if (mag >= MAG_MAX)
			return SW'(-MAG_MAX);
		return $urandom_range(0, 1) ? SW'(-mag) : SW'(mag);
	endfunction

	function automatic logic signed [SW-1:0] pick_current();
		int thr;
		int m;
		thr = cur_lim * 3 / 5;
		case ($urandom_range(0, 7))
			0: m = 0;
			1: m = MAG_MAX;
			2, 3: m = thr + int'($urandom_range(0, 4)) - 2;
			4: m = cur_lim + int'($urandom_range(0, 4)) - 2;
			default: m = $urandom_range(0, MAG_MAX);
		endcase
		if (m < 0)
			m = 0;
		return signed_of(m);
	endfunction

	function automatic logic [SW-1:0] pick_voltage();
		int v;
		case ($urandom_range(0, 5))
			0, 1: v = volt_lim + int'($urandom_range(0, 2)) - 1;
			2: v = 65535;
			3: v = 0;
			default: v = $urandom_range(0, 65535);
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return SW'(v);
	endfunction

	function automatic logic [mfs_pkg::COST_W-1:0] pick_cost();
		case ($urandom_range(0, 7))
			0: return cost_lim;
			1: return cost_lim + 32'd1;
			2: return cost_lim - 32'd1;
			3: return 32'hFFFF_FFFF;
			4: return 32'd0;
			default: return $urandom();
		endcase
	endfunction

	function automatic sample_t make_sample(input run_kind_t kind);
		sample_t              s;
		int                   thr;
		int                   lo;
		logic signed [SW-1:0] tmp;
		thr = cur_lim * 3 / 5;
		lo  = (thr + 1 > cur_lim) ? cur_lim : thr + 1;
		s.vdc  = SW'($urandom_range(0, volt_lim));
		s.cost = pick_cost();
		case (kind)
			RUN_STALL: begin
				s.ia  = signed_of($urandom_range(lo, cur_lim));
				s.ib  = '0;
				s.spd = (stall_spd > 0) ? signed_of($urandom_range(0, stall_spd - 1))
				                        : SW'($urandom());
			end
			RUN_CALM: begin
				s.ia  = signed_of($urandom_range(0, thr));
				s.ib  = '0;
				s.spd = SW'($urandom());
			end
			default: begin
				s.ia  = pick_current();
				s.ib  = pick_current();
				s.vdc = pick_voltage();
				case ($urandom_range(0, 4))
					0: s.spd = SW'(-MAG_MAX);
					1: s.spd = signed_of(stall_spd);
					2: s.spd = signed_of((stall_spd > 0) ? stall_spd - 1 : 0);
					default: s.spd = SW'($urandom());
				endcase
			end
		endcase
		if ($urandom_range(0, 1)) begin
			tmp  = s.ia;
			s.ia = s.ib;
			s.ib = tmp;
		end
		return s;
	endfunction

	task automatic send_sample(input sample_t s);
		int gap;
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			sample.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample.valid         = 1'b1;
		sample.current_alpha = s.ia;
		sample.current_beta  = s.ib;
		sample.bus_voltage   = s.vdc;
		sample.rotor_speed   = s.spd;
		sample.control_cost  = s.cost;
		do @(posedge clk); while (!sample.ready);
		n_sent++;
	endtask

	task automatic offer(input int ia, input int ib, input int vdc, input int spd,
		input logic [31:0] cost);
		sample_t s;
		s.ia   = SW'(ia);
		s.ib   = SW'(ib);
		s.vdc  = SW'(vdc);
		s.spd  = SW'(spd);
		s.cost = cost;
		send_sample(s);
	endtask

	task automatic drain_results();
		@(negedge clk);
		sample.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Bits above the register width carry random junk that the block must drop.
	task automatic write_reg(input logic [mfs_pkg::CFG_INDEX_W-1:0] idx, input int width,
		input logic [mfs_pkg::CFG_DATA_W-1:0] value);
		logic [mfs_pkg::CFG_DATA_W-1:0] mask;
		mask = (width >= mfs_pkg::CFG_DATA_W) ? '1
			: (mfs_pkg::CFG_DATA_W'(1) << width) - 1'b1;
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_wdata = (value & mask) | ($urandom() & ~mask);
	endtask

	task automatic apply_settings(input int cl, input int vl, input int ss, input int sm,
		input logic [31:0] cost);
		drain_results();
		write_reg(mfs_pkg::CFG_CURRENT_LIMIT, mfs_pkg::CUR_LIMIT_W, cl);
		write_reg(mfs_pkg::CFG_VOLTAGE_LIMIT, mfs_pkg::VOLT_LIMIT_W, vl);
		write_reg(mfs_pkg::CFG_STALL_SPEED, mfs_pkg::STALL_SPEED_W, ss);
		write_reg(mfs_pkg::CFG_STALL_COUNT_MAX, mfs_pkg::STALL_MAX_W, sm);
		write_reg(mfs_pkg::CFG_DIV_LIMIT, mfs_pkg::COST_W, cost);
		if ($urandom_range(0, 1))
			write_reg(mfs_pkg::CFG_INDEX_W'(mfs_pkg::CFG_DIV_LIMIT + $urandom_range(1, 3)),
				mfs_pkg::CFG_DATA_W, $urandom());
		@(negedge clk);
		cfg_wen   = 1'b0;
		cur_lim   = cl;
		volt_lim  = vl;
		stall_spd = ss;
		stall_max = sm;
		cost_lim  = cost;
		n_settings++;
	endtask

	task automatic random_settings();
		int          cl;
		int          vl;
		int          ss;
		int          sm;
		logic [31:0] cost;
		case ($urandom_range(0, 3))
			0: cl = $urandom_range(0, 40);
			1: cl = 32767;
			default: cl = $urandom_range(0, 32767);
		endcase
		vl   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
		                                   : $urandom_range(30000, 65535);
		ss   = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 32767);
		sm   = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 12);
		cost = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1000) : $urandom();
		apply_settings(cl, vl, ss, sm, cost);
	endtask

	task automatic run_phase(input int n_items);
		int        done;
		int        len;
		run_kind_t kind;
		done = 0;
		while (done < n_items) begin
			case ($urandom_range(0, 3))
				0, 1: kind = RUN_STALL;
				2: kind = RUN_CALM;
				default: kind = RUN_NOISE;
			endcase
			len = $urandom_range(1, 16);
			repeat (len) if (done < n_items) begin
				send_sample(make_sample(kind));
				done++;
			end
		end
	endtask

	initial begin
		sample.valid         = 1'b0;
		sample.current_alpha = '0;
		sample.current_beta  = '0;
		sample.bus_voltage   = '0;
		sample.rotor_speed   = '0;
		sample.control_cost  = '0;
		result.ready         = 1'b0;
		tx_idle_en           = 1'b1;
		rx_idle_en           = 1'b1;
		rx_hold_req          = 1'b0;
		cur_lim              = mfs_pkg::CUR_LIMIT_RST;
		volt_lim             = mfs_pkg::VOLT_LIMIT_RST;
		stall_spd            = mfs_pkg::STALL_SPEED_RST;
		stall_max            = mfs_pkg::STALL_MAX_RST;
		cost_lim             = mfs_pkg::DIV_LIMIT_RST;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		offer(0, 0, 0, 0, 0);
		offer(-32768, -32768, 0, 0, 0);
		offer(32767, 0, 65535, 32767, 32'hFFFF_FFFF);
		offer(0, -32768, 0, 0, 0);
		offer(0, 0, 0, -32768, 0);

		apply_settings(1000, 40000, 100, 2, 5000);
		offer(0, 0, 40001, 0, 0);
		offer(1001, 0, 40001, 0, 0);
		offer(700, 0, 0, 0, 0);
		offer(-700, 0, 0, -99, 0);
		offer(0, 1001, 0, 0, 0);
		offer(601, 0, 0, 50, 6000);
		offer(600, 0, 0, 0, 5001);
		offer(700, 0, 0, 100, 5000);
		offer(480, -360, 0, 0, 0);
		offer(0, 0, 0, 0, 0);

		apply_settings(0, 0, 32767, 0, 0);
		offer(0, 0, 0, 0, 0);
		offer(1, 0, 0, 0, 0);
		offer(0, -1, 0, 0, 0);
		offer(0, 0, 1, 0, 0);
		offer(0, 0, 0, 0, 1);
		offer(0, 0, 0, -32768, 0);

		apply_settings(32767, 65535, 32767, 65535, 32'hFFFF_FFFF);
		run_phase(50);
		apply_settings(0, 0, 0, 0, 0);
		run_phase(50);
		repeat (6) begin
			random_settings();
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			run_phase(50);
		end

		// The receiver holds off while samples keep coming, then the sender
		// waits for every verdict before carrying on.
		random_settings();
		tx_idle_en  = 1'b0;
		rx_idle_en  = 1'b1;
		rx_hold_req = 1'b1;
		run_phase(30);
		drain_results();
		run_phase(30);

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (2) begin
			random_settings();
			run_phase(40);
		end

		apply_settings(32767, 65535, 32767, 65535, 32'hFFFF_FFFF);
		repeat (8) offer(0, 0, 0, 1000, 0);
		drain_results();

		$display("Sent %0d samples under %0d register settings, with stalls and drains.",
			n_sent, n_settings);
		$display("Verdicts seen: %0d fault, %0d degraded.", n_fault, n_degraded);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/mfs_pkg.sv
rtl/mfs_if.sv
rtl/motor_fault_supervisor.sv
rtl/mfs_checker.sv
dv/mfs_verdict_checker.sv
dv/tb_motor_fault_supervisor.sv
